[hdl/mbr_pkg.sv]
package mbr_pkg;

    // Q4.60 fixed point for the c and z components
    localparam int unsigned FRAC_BITS = 60;

    // |z|^2 escape bound: 4.0 at 2*FRAC_BITS fraction bits
    localparam logic [127:0] ESC_THRESH = 128'd1 << (2 * FRAC_BITS + 2);

    localparam logic [12:0] LIMIT_CAP   = 13'd4096;
    localparam logic [12:0] LIMIT_RESET = 13'd64;

    // Last step of one 64x64 product on the shared multiplier
    localparam logic [2:0] STEP_CAPTURE = 3'd5;
    localparam logic [2:0] STEP_ISSUES  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIFF,
        ST_UPDATE,
        ST_MAG,
        ST_DONE
    } mbr_state_t;

    typedef enum logic [1:0] {
        PROD_RR,
        PROD_II,
        PROD_RI
    } mbr_prod_t;

    typedef struct packed {
        logic      idle;
        logic      mul_active;
        logic      mac_issue;
        logic [1:0] mac_sel;
        logic      mac_clr;
        logic      cap_en;
        mbr_prod_t cap_idx;
        logic      diff_en;
        logic      upd_en;
        logic      done;
    } mbr_ctrl_t;

    // Magnitude of a two's complement word; -2^63 gives 2^63 unsigned
    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Clamp a 128-bit signed value to the 64-bit signed range
    function automatic logic [63:0] sat64(input logic [127:0] v);
        logic [63:0] r;
        if (v[127:63] == {65{v[63]}})
        begin
            r = v[63:0];
        end
        else if (v[127])
        begin
            r = {1'b1, 63'd0};
        end
        else
        begin
            r = {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

endpackage

[hdl/mbr_mac.sv]
module mbr_mac (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         issue,
    input  logic [1:0]   sel,
    input  logic         clr,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] acc
);
    import mbr_pkg::*;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  prod_reg;
    logic [1:0]   shamt_reg;
    logic         pvld_reg;
    logic [127:0] acc_reg;
    logic [127:0] acc_next;
    logic [127:0] shifted;

    // sel[1] picks the upper half of a, sel[0] the upper half of b
    assign a_half = sel[1] ? a[63:32] : a[31:0];
    assign b_half = sel[0] ? b[63:32] : b[31:0];

    // 32x32 partial product, registered
    always_ff @(posedge clk)
    begin
        prod_reg  <= a_half * b_half;
        shamt_reg <= {1'b0, sel[1]} + {1'b0, sel[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
        end
        else
        begin
            pvld_reg <= issue;
        end
    end

    // align the partial product by 32-bit words
    always_comb
    begin
        case (shamt_reg)
            2'd0:    shifted = {64'd0, prod_reg};
            2'd1:    shifted = {32'd0, prod_reg, 32'd0};
            2'd2:    shifted = {prod_reg, 64'd0};
            default: shifted = 128'd0;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (clr)
        begin
            acc_next = 128'd0;
        end
        else if (pvld_reg)
        begin
            acc_next = acc_reg + shifted;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[hdl/mbr_seq.sv]
module mbr_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              below_thresh,
    input  logic [12:0]       limit,
    input  logic              out_free,
    output mbr_pkg::mbr_ctrl_t ctrl,
    output logic [12:0]       count
);
    import mbr_pkg::*;

    mbr_state_t state_reg;
    mbr_state_t state_next;
    mbr_prod_t  prod_reg;
    mbr_prod_t  prod_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic [12:0] count_reg;
    logic [12:0] count_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        step_next  = step_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                    prod_next  = PROD_RR;
                    step_next  = 3'd0;
                    count_next = 13'd0;
                end
            end
            ST_MUL:
            begin
                if (step_reg == STEP_CAPTURE)
                begin
                    step_next = 3'd0;
                    case (prod_reg)
                        PROD_RR: prod_next  = PROD_II;
                        PROD_II: state_next = ST_CHECK;
                        PROD_RI: state_next = ST_DIFF;
                        default: state_next = ST_IDLE;
                    endcase
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_CHECK:
            begin
                if (!below_thresh || (count_reg >= limit))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL;
                    prod_next  = PROD_RI;
                    step_next  = 3'd0;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_MAG;
                count_next = count_reg + 13'd1;
            end
            ST_MAG:
            begin
                state_next = ST_MUL;
                prod_next  = PROD_RR;
                step_next  = 3'd0;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prod_reg  <= PROD_RR;
            step_reg  <= 3'd0;
            count_reg <= 13'd0;
        end
        else
        begin
            state_reg <= state_next;
            prod_reg  <= prod_next;
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

    // outputs
    always_comb
    begin
        ctrl            = '0;
        ctrl.idle       = (state_reg == ST_IDLE);
        ctrl.mul_active = (state_reg == ST_MUL);
        ctrl.mac_issue  = (state_reg == ST_MUL) && (step_reg < STEP_ISSUES);
        ctrl.mac_sel    = step_reg[1:0];
        ctrl.mac_clr    = (state_reg == ST_IDLE)
                          || ((state_reg == ST_MUL) && (step_reg == STEP_CAPTURE));
        ctrl.cap_en     = (state_reg == ST_MUL) && (step_reg == STEP_CAPTURE);
        ctrl.cap_idx    = prod_reg;
        ctrl.diff_en    = (state_reg == ST_DIFF);
        ctrl.upd_en     = (state_reg == ST_UPDATE);
        ctrl.done       = (state_reg == ST_DONE) && out_free;
    end

    assign count = count_reg;

endmodule

[hdl/mandelbrot_escape_time.sv]
// Each iteration: products zr*zr and zi*zi, the escape check, zr*zi, then diff, update, mag.
// One 32x32 multiplier builds each 64x64 product from partial products; 3 products per update.
// Throughput: one point at a time; no new point is taken while one is in progress.
// The next point is taken while the previous result still waits on the output.
// Reset: asynchronous, active low; the iteration limit returns to 64, output empty.
module mandelbrot_escape_time (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [12:0]  cfg_data,     // max_iterations
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,      // [63:0] c_real, [127:64] c_imag
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata       // [11:0] escape_count, [15:12] zero
);
    import mbr_pkg::*;

    mbr_ctrl_t    ctrl;
    logic [12:0]  count;
    logic [12:0]  max_it_reg;
    logic [12:0]  limit;
    logic         start;
    logic         below_thresh;
    logic         out_free;

    logic [63:0]  cr_reg;
    logic [63:0]  ci_reg;
    logic [63:0]  zr_reg;
    logic [63:0]  zi_reg;
    logic [63:0]  zr_mag_reg;
    logic [63:0]  zi_mag_reg;
    logic [127:0] rr_reg;
    logic [127:0] ii_reg;
    logic [127:0] ri_reg;
    logic signed [127:0] diff_reg;
    logic signed [127:0] ris_reg;
    logic signed [127:0] nr_sh;
    logic signed [127:0] ni_sh;
    logic [127:0] nr_sum;
    logic [127:0] ni_sum;
    logic [127:0] mag_sum;
    logic [127:0] acc;
    logic [63:0]  op_a;
    logic [63:0]  op_b;
    logic         m_tvalid_reg;
    logic [11:0]  esc_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_it_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_it_reg <= cfg_data;
        end
    end

    assign limit = (max_it_reg > LIMIT_CAP) ? LIMIT_CAP : max_it_reg;

    assign s_tready = ctrl.idle;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    mbr_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .below_thresh (below_thresh),
        .limit        (limit),
        .out_free     (out_free),
        .ctrl         (ctrl),
        .count        (count)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        case (ctrl.cap_idx)
            PROD_RR:
            begin
                op_a = zr_mag_reg;
                op_b = zr_mag_reg;
            end
            PROD_II:
            begin
                op_a = zi_mag_reg;
                op_b = zi_mag_reg;
            end
            PROD_RI:
            begin
                op_a = zr_mag_reg;
                op_b = zi_mag_reg;
            end
            default:
            begin
                op_a = 64'd0;
                op_b = 64'd0;
            end
        endcase
    end

    mbr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (ctrl.mac_issue),
        .sel   (ctrl.mac_sel),
        .clr   (ctrl.mac_clr),
        .a     (op_a),
        .b     (op_b),
        .acc   (acc)
    );

    // escape test on |z|^2
    assign mag_sum      = rr_reg + ii_reg;
    assign below_thresh = (mag_sum < ESC_THRESH);

    // new z, rounded toward minus infinity
    assign nr_sh  = diff_reg >>> FRAC_BITS;
    assign ni_sh  = ris_reg >>> (FRAC_BITS - 1);
    assign nr_sum = nr_sh + {{64{cr_reg[63]}}, cr_reg};
    assign ni_sum = ni_sh + {{64{ci_reg[63]}}, ci_reg};

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cr_reg     <= s_tdata[63:0];
            ci_reg     <= s_tdata[127:64];
            zr_reg     <= 64'd0;
            zi_reg     <= 64'd0;
            zr_mag_reg <= 64'd0;
            zi_mag_reg <= 64'd0;
        end
        else
        begin
            zr_mag_reg <= mag64(zr_reg);
            zi_mag_reg <= mag64(zi_reg);
            if (ctrl.upd_en)
            begin
                zr_reg <= sat64(nr_sum);
                zi_reg <= sat64(ni_sum);
            end
        end
        if (ctrl.cap_en)
        begin
            case (ctrl.cap_idx)
                PROD_RR: rr_reg <= acc;
                PROD_II: ii_reg <= acc;
                PROD_RI: ri_reg <= acc;
                default: ri_reg <= acc;
            endcase
        end
        if (ctrl.diff_en)
        begin
            diff_reg <= rr_reg - ii_reg;
            ris_reg  <= (zr_reg[63] ^ zi_reg[63]) ? (128'd0 - ri_reg) : ri_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctrl.done)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done)
        begin
            esc_reg <= (count < limit) ? count[11:0] : 12'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, esc_reg};

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a point is in progress");

    a_mag_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mul_active |-> ((zr_mag_reg == mag64(zr_reg)) && (zi_mag_reg == mag64(zi_reg))))
        else $error("multiplier operands stale");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.done |-> (count <= limit))
        else $error("update count passed the limit");

    a_result_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((esc_reg == 12'd0) || ({1'b0, esc_reg} < limit)))
        else $error("escape count not below the limit");
`endif

endmodule

[tb/mandelbrot_escape_time_tb.sv]
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;

    // Q4.60 constants for the predictor and the stimulus
    localparam int unsigned FRAC           = 60;
    localparam logic [127:0] ESCAPE_BOUND  = 128'd1 << (2 * FRAC + 2);
    localparam logic [12:0]  LIMIT_CEILING = 13'd4096;
    localparam logic [12:0]  LIMIT_AT_RESET = 13'd64;
    localparam logic [12:0]  LIMIT_ALL_ONES = 13'h1FFF;
    localparam logic [63:0]  Q_ONE         = 64'd1 << FRAC;
    localparam logic [63:0]  Q_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]  Q_MIN         = 64'h8000_0000_0000_0000;
    localparam logic [63:0]  Q_NEG_TWO     = 64'hE000_0000_0000_0000;
    localparam logic [63:0]  Q_NEG_ONE     = 64'hF000_0000_0000_0000;
    localparam logic [63:0]  Q_ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [12:0]  cfg_data = 13'd0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = 128'd0;     // [63:0] c_real, [127:64] c_imag
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;              // [11:0] escape_count, [15:12] zero

    // Escape counts predicted for accepted points, oldest first
    logic [11:0]  expected_counts[$];
    logic [11:0]  want_count;
    logic [12:0]  limit_shadow = LIMIT_AT_RESET;

    int unsigned  error_count = 0;
    int unsigned  points_sent = 0;
    int unsigned  results_checked = 0;
    int unsigned  limits_used = 0;

    // Idling control for both sides
    logic         tx_idle_on = 1'b1;
    logic         rx_idle_on = 1'b1;
    int unsigned  rx_gap_left = 0;
    int unsigned  rx_hold_left = 0;

    mandelbrot_escape_time uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 clk = ~clk;

    // Clamp to the signed 64-bit range
    function automatic logic [63:0] clamp_q(input logic signed [127:0] v);
        if (v[127:63] == {65{v[127]}})
        begin
            return v[63:0];
        end
        return v[127] ? Q_MIN : Q_MAX;
    endfunction

    // Iterate z = z^2 + c from zero; 0 means the limit was reached
    function automatic logic [11:0] escape_iterations(input logic [63:0] cr,
                                                      input logic [63:0] ci,
                                                      input logic [12:0] lim_reg);
        logic signed [127:0] zr;
        logic signed [127:0] zi;
        logic signed [127:0] rr;
        logic signed [127:0] ii;
        logic signed [127:0] ri;
        logic signed [127:0] cr_w;
        logic signed [127:0] ci_w;
        logic [127:0]        mag;
        int unsigned         limit;
        int unsigned         count;
        limit = (lim_reg > LIMIT_CEILING) ? LIMIT_CEILING : lim_reg;
        count = 0;
        zr = 0;
        zi = 0;
        cr_w = $signed(cr);
        ci_w = $signed(ci);
        while (1'b1)
        begin
            rr = zr * zr;
            ii = zi * zi;
            ri = zr * zi;
            // both squares are non-negative; the sum fits unsigned
            mag = rr + ii;
            if (mag >= ESCAPE_BOUND || count >= limit)
            begin
                break;
            end
            zr = $signed(clamp_q(((rr - ii) >>> FRAC) + cr_w));
            zi = $signed(clamp_q((ri >>> (FRAC - 1)) + ci_w));
            count++;
        end
        return (count < limit) ? 12'(count) : 12'd0;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 16);
        end
        return $urandom_range(40, 250);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= 40)
        begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Mostly points around the set, some anywhere in the Q4.60 range
    task automatic pick_point(output logic [63:0] cr, output logic [63:0] ci);
        logic [63:0] raw_r;
        logic [63:0] raw_i;
        raw_r = {$urandom, $urandom};
        raw_i = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0)
        begin
            cr = raw_r;
            ci = raw_i;
        end
        else
        begin
            cr = ($signed(raw_r) >>> 2) - (Q_ONE >> 1);
            ci = $signed(raw_i) >>> 2;
        end
    endtask

    // Offer one point, predict its count on acceptance
    task automatic send_point(input logic [63:0] cr, input logic [63:0] ci);
        int unsigned gap;
        s_tdata  <= {ci, cr};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (s_tready !== 1'b1);
        expected_counts.push_back(escape_iterations(cr, ci, limit_shadow));
        points_sent++;
        gap = tx_idle_on ? gap_cycles() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding count
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_counts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write the iteration limit once the unit is idle
    task automatic set_limit(input logic [12:0] value);
        drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        limit_shadow = value;
        limits_used++;
    endtask

    // Extremes and known points at the reset limit
    task automatic test_reset_limit();
        send_point(64'd0, 64'd0);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_MIN, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_NEG_TWO, 64'd0);
        send_point(Q_NEG_TWO + 64'd1, 64'd0);
        send_point(64'd0, Q_NEG_TWO);
        send_point(Q_ONE << 1, 64'd0);
        send_point(Q_ONE >> 2, 64'd0);
        send_point(Q_NEG_ONE, 64'd0);
        send_point(64'd0, Q_ONE);
        send_point(Q_ALL_ONES, Q_ALL_ONES);
        send_point((Q_ONE >> 2) + (Q_ONE >> 4), 64'd0);
    endtask

    // Zero limit: no update at all, always 0
    task automatic test_zero_limit();
        set_limit(13'd0);
        send_point(64'd0, 64'd0);
        send_point(Q_MAX, Q_MAX);
        send_point((Q_ONE >> 2) + (Q_ONE >> 4), 64'd0);
    endtask

    // Limit of one: an escape on the first update still reads as 0
    task automatic test_limit_one();
        set_limit(13'd1);
        send_point(64'd0, 64'd0);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_NEG_TWO, 64'd0);
    endtask

    // Full cap: one point inside, one escaping after a few thousand updates
    task automatic test_limit_cap();
        set_limit(LIMIT_CEILING);
        send_point(64'd0, 64'd0);
        send_point((Q_ONE >> 2) + (64'd1 << 40), 64'd0);
    endtask

    // Limit above range works as the cap
    task automatic test_limit_above_range();
        set_limit(LIMIT_ALL_ONES);
        send_point(64'd0, 64'd0);
        send_point(Q_MAX, Q_MIN);
    endtask

    // Random points over several limits, one phase with no idling
    task automatic test_random_points(input int unsigned phases,
                                      input int unsigned per_phase);
        logic [63:0] cr;
        logic [63:0] ci;
        for (int unsigned p = 0; p < phases; p++)
        begin
            set_limit((p == 0) ? 13'd2 : 13'($urandom_range(3, 100)));
            tx_idle_on = (p != 1);
            rx_idle_on = (p != 1);
            for (int unsigned n = 0; n < per_phase; n++)
            begin
                pick_point(cr, ci);
                send_point(cr, ci);
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver holds off long while points keep coming, so the input stalls
    task automatic test_output_stall();
        logic [63:0] cr;
        logic [63:0] ci;
        set_limit(13'd12);
        @(negedge clk);
        rx_hold_left = 2000;
        @(posedge clk);
        tx_idle_on = 1'b0;
        for (int unsigned n = 0; n < 12; n++)
        begin
            pick_point(cr, ci);
            send_point(cr, ci);
        end
        tx_idle_on = 1'b1;
    endtask

    // Receiver: random stalls plus an optional long hold
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_gap_left != 0)
        begin
            m_tready    <= 1'b0;
            rx_gap_left <= rx_gap_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                rx_gap_left <= gap_cycles();
            end
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (expected_counts.size() == 0)
            begin
                report_mismatch("result beat with no point outstanding", m_tdata, 0);
            end
            else
            begin
                want_count = expected_counts.pop_front();
                if (m_tdata[11:0] !== want_count)
                begin
                    report_mismatch("escape_count", m_tdata[11:0], want_count);
                end
                if (m_tdata[15:12] !== 4'd0)
                begin
                    report_mismatch("m_tdata padding", m_tdata[15:12], 0);
                end
                results_checked++;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_limit();
        test_zero_limit();
        test_limit_one();
        test_limit_cap();
        test_limit_above_range();
        test_random_points(5, 21);
        test_output_stall();

        drain();
        repeat (60) @(posedge clk);

        $display("Ran %0d points over %0d limit writes: limits 0, 1, 4096 and 8191,",
                 points_sent, limits_used);
        $display("random limits, idle gaps and a long output hold; %0d counts checked.",
                 results_checked);
        if (error_count == 0 && expected_counts.size() == 0)
        begin
            $display("mandelbrot_escape_time regression: pass");
        end
        else
        begin
            $display("mandelbrot_escape_time regression: fail");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run
    initial
    begin
        #50_000_000;
        $display("Timeout with %0d counts outstanding", expected_counts.size());
        $display("mandelbrot_escape_time regression: fail");
        $finish;
    end

endmodule
